/* src/pifu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pifu_pkg;

   // Field sizing
   localparam int unsigned MAX_FIELD_DEF = 64;  // default field limit
   localparam int unsigned FIELD_CAP     = 64;  // hard ceiling on characters per field
   localparam int unsigned MAX_DIGITS    = 22;  // enough octal digits for 64 bits
   localparam int unsigned DIG_IDX_W     = $clog2(MAX_DIGITS);
   localparam int unsigned DIG_CNT_W     = $clog2(MAX_DIGITS + 1);
   localparam int unsigned VALUE_W       = 64;
   localparam int unsigned CHAR_W        = 8;
   localparam int unsigned POS_W         = 7;   // holds 0..FIELD_CAP
   localparam int unsigned PREC_W        = 6;
   localparam int unsigned ITER_W        = 7;   // holds 0..VALUE_W
   localparam int unsigned CSR_IDX_W     = 3;
   localparam int unsigned CSR_DATA_W    = 7;

   // ASCII
   localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'h58;
   localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;

   typedef enum logic [2:0] {
      CONV_SDEC = 3'd0,
      CONV_UDEC = 3'd1,
      CONV_HEXL = 3'd2,
      CONV_HEXU = 3'd3,
      CONV_OCT  = 3'd4
   } conv_type;

   typedef enum logic [1:0] {
      LEN_32 = 2'd0,
      LEN_16 = 2'd1,
      LEN_64 = 2'd2
   } len_type;

   typedef enum logic [1:0] {
      SGN_MINUS = 2'd0,
      SGN_SPACE = 2'd1,
      SGN_PLUS  = 2'd2
   } sign_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CONVERSION  = 3'd0,
      CSR_LENGTH_MODE = 3'd1,
      CSR_LEFT_JUST   = 3'd2,
      CSR_SIGN_MODE   = 3'd3,
      CSR_ZERO_PAD    = 3'd4,
      CSR_ALT_FORM    = 3'd5,
      CSR_FIELD_WIDTH = 3'd6,
      CSR_MIN_DIGITS  = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'd0,
      ST_DABBLE = 3'd1,
      ST_SCAN   = 3'd2,
      ST_PREP   = 3'd3,
      ST_LAYOUT = 3'd4,
      ST_EMIT   = 3'd5
   } fsm_state_type;

   typedef enum logic [2:0] {
      DU_HOLD     = 3'd0,
      DU_LOAD_HEX = 3'd1,
      DU_LOAD_OCT = 3'd2,
      DU_LOAD_DEC = 3'd3,
      DU_DABBLE   = 3'd4
   } du_op_type;

   typedef struct packed {
      du_op_type              op;
      logic [DIG_IDX_W-1:0]   rd_idx;
   } du_ctl_type;

   typedef struct packed {
      logic [2:0]             conversion;
      logic [1:0]             length_mode;
      logic                   left_just;
      logic [1:0]             sign_mode;
      logic                   zero_pad;
      logic                   alt_form;
      logic [6:0]             field_width;
      logic signed [6:0]      min_digits;
   } cfg_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
      logic [CHAR_W-1:0] base_ch;
      base_ch = upper ? CH_UPPER_A : CH_LOWER_A;
      if (d < 4'd10) begin
         digit_char = CH_ZERO + CHAR_W'(d);
      end else begin
         digit_char = base_ch + CHAR_W'(d) - CHAR_W'(10);
      end
   endfunction

endpackage

`default_nettype wire

/* src/pifu_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none

interface pifu_req_if;
   import pifu_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [VALUE_W-1:0]   raw_value;
   modport source (output valid, output raw_value, input ready);
   modport sink   (input valid, input raw_value, output ready);
endinterface

interface pifu_rsp_if;
   import pifu_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CHAR_W-1:0]    out_char;
   logic                 last;
   logic                 empty_field;
   modport source (output valid, output out_char, output last, output empty_field, input ready);
   modport sink   (input valid, input out_char, input last, input empty_field, output ready);
endinterface

interface pifu_csr_if;
   import pifu_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CSR_IDX_W-1:0]    reg_index;
   logic [CSR_DATA_W-1:0]   wdata;
   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

/* src/printf_integer_field_formatter_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// printf-style integer field formatter (%d %u %x %X %o).
// Channels: csr_bus writes the format registers (index, data; always ready, write
// only while no value is in flight). req_bus takes one 64-bit raw value per
// transaction; rsp_bus returns the field one ASCII character per transaction, with
// last on the final one. An empty field gives one transaction with empty_field
// and last set and a NUL character.
// Steps per value: the accept state, then for decimal one double-dabble step per bit
// of the length mode on the shared BCD unit, then a top-down digit-count scan over
// the digit store, the prep and layout states, then one character per cycle while rsp_bus keeps up.
// The block takes a new value only once the previous field has been fully handed
// to the output register.
// The output register decouples the receiver: a stalled rsp_bus holds the current
// character and freezes the character sequencer; nothing is dropped.
// Reset (synchronous, active high) returns the sequencer to idle, clears the
// output valid and restores the registers to their defaults (precision not given).
module printf_integer_field_formatter_unit #(
   parameter int unsigned MAX_FIELD = pifu_pkg::MAX_FIELD_DEF
) (
   input  logic        clock,
   input  logic        reset,
   pifu_csr_if.sink    csr_bus,
   pifu_req_if.sink    req_bus,
   pifu_rsp_if.source  rsp_bus
);
   import pifu_pkg::*;

   localparam int unsigned FIELD_LIMIT = (MAX_FIELD < FIELD_CAP) ? MAX_FIELD : FIELD_CAP;
   localparam logic [POS_W-1:0]  LIMIT_POS = POS_W'(FIELD_LIMIT);
   localparam logic [PREC_W-1:0] PREC_CAP  = PREC_W'(FIELD_LIMIT - 2);

   cfg_type                 cfg;
   du_ctl_type              du_ctl;
   logic [VALUE_W-1:0]      du_load;
   logic [3:0]              rd_digit;

   // sequencer state
   fsm_state_type           state_ff, state_in;
   conv_type                conv_ff, conv_in;
   logic                    neg_ff, neg_in;
   logic                    mag_nz_ff, mag_nz_in;
   logic [ITER_W-1:0]       iter_ff, iter_in;
   logic [DIG_IDX_W-1:0]    scan_idx_ff, scan_idx_in;
   logic [DIG_CNT_W-1:0]    dcnt_ff, dcnt_in;
   logic [DIG_IDX_W-1:0]    dig_idx_ff, dig_idx_in;
   logic [PREC_W-1:0]       ndig_ff, ndig_in;
   logic [1:0]              plen_ff, plen_in;
   logic                    sgn_ff, sgn_in;
   logic [CHAR_W-1:0]       sgn_ch_ff, sgn_ch_in;
   // layout boundaries: spaces | sign | prefix | zeros | digits | spaces
   logic [POS_W-1:0]        b1_ff, b1_in, b2_ff, b2_in, b3_ff, b3_in;
   logic [POS_W-1:0]        b4_ff, b4_in, b5_ff, b5_in;
   logic [POS_W-1:0]        total_ff, total_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]       char_ff, char_in;
   logic                    last_ff, last_in;
   logic                    empty_ff, empty_in;

   // accept-cycle operand shaping
   conv_type                conv_norm;
   logic [VALUE_W-1:0]      mask, sign_bit, val, mag, mag_just;
   logic [ITER_W-1:0]       iter_len;
   logic                    neg_now;
   // prep / layout
   logic                    has_prec, zfill, upper, out_load, req_fire;
   logic [PREC_W-1:0]       prec, dcnt6, ndig_now;
   logic [POS_W-1:0]        body, wsat, pad, lead_sp, zpad, prec_zeros;

   pifu_csr_regs u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   pifu_digit_unit u_digits (
      .clock      (clock),
      .ctl        (du_ctl),
      .load_value (du_load),
      .rd_digit   (rd_digit)
   );

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign req_fire            = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.out_char    = char_ff;
   assign rsp_bus.last        = last_ff;
   assign rsp_bus.empty_field = empty_ff;

   assign out_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_bus.ready);
   assign upper    = (conv_ff == CONV_HEXU);

   // operand: truncate by length mode, sign from that width's top bit, magnitude formed unsigned
   always_comb begin
      conv_norm = (cfg.conversion > 3'd4) ? CONV_UDEC : conv_type'(cfg.conversion);
      priority if (cfg.length_mode == LEN_16) begin
         mask     = VALUE_W'(16'hFFFF);
         sign_bit = VALUE_W'(16'h8000);
         iter_len = ITER_W'(16);
      end else if (cfg.length_mode == LEN_64) begin
         mask     = '1;
         sign_bit = {1'b1, {(VALUE_W-1){1'b0}}};
         iter_len = ITER_W'(64);
      end else begin
         mask     = VALUE_W'(32'hFFFF_FFFF);
         sign_bit = VALUE_W'(32'h8000_0000);
         iter_len = ITER_W'(32);
      end
      val     = req_bus.raw_value & mask;
      neg_now = (conv_norm == CONV_SDEC) && ((val & sign_bit) != '0);
      mag     = neg_now ? ((~val + VALUE_W'(1)) & mask) : val;
      // left-justify so the dabble steps see the top bit first
      priority if (cfg.length_mode == LEN_16) begin
         mag_just = mag << 48;
      end else if (cfg.length_mode == LEN_64) begin
         mag_just = mag;
      end else begin
         mag_just = mag << 32;
      end
   end

   // precision, digit total and prefix
   always_comb begin
      has_prec = !cfg.min_digits[6];
      prec     = has_prec ? cfg.min_digits[5:0] : PREC_W'(1);
      if (has_prec && (prec > PREC_CAP)) prec = PREC_CAP;
      dcnt6    = PREC_W'(dcnt_ff);
      ndig_now = (dcnt6 > prec) ? dcnt6 : prec;
      zfill    = cfg.zero_pad && !cfg.left_just && !has_prec;
      body     = POS_W'(sgn_ff) + POS_W'(plen_ff) + POS_W'(ndig_ff);
      wsat     = (cfg.field_width > LIMIT_POS) ? LIMIT_POS : cfg.field_width;
      pad      = (wsat > body) ? wsat - body : '0;
      lead_sp  = (!cfg.left_just && !zfill) ? pad : '0;
      zpad     = zfill ? pad : '0;
      prec_zeros = POS_W'(ndig_ff - dcnt6);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      conv_in      = conv_ff;
      neg_in       = neg_ff;
      mag_nz_in    = mag_nz_ff;
      iter_in      = iter_ff;
      scan_idx_in  = scan_idx_ff;
      dcnt_in      = dcnt_ff;
      dig_idx_in   = dig_idx_ff;
      ndig_in      = ndig_ff;
      plen_in      = plen_ff;
      sgn_in       = sgn_ff;
      sgn_ch_in    = sgn_ch_ff;
      b1_in        = b1_ff;
      b2_in        = b2_ff;
      b3_in        = b3_ff;
      b4_in        = b4_ff;
      b5_in        = b5_ff;
      total_in     = total_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      char_in      = char_ff;
      last_in      = last_ff;
      empty_in     = empty_ff;
      du_ctl.op     = DU_HOLD;
      du_ctl.rd_idx = (state_ff == ST_SCAN) ? scan_idx_ff : dig_idx_ff;
      du_load       = mag;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               conv_in     = conv_norm;
               neg_in      = neg_now;
               mag_nz_in   = (mag != '0);
               iter_in     = iter_len;
               scan_idx_in = DIG_IDX_W'(MAX_DIGITS - 1);
               unique case (conv_norm)
                  CONV_SDEC, CONV_UDEC: begin
                     du_ctl.op = DU_LOAD_DEC;
                     du_load   = mag_just;
                     state_in  = ST_DABBLE;
                  end
                  CONV_HEXL, CONV_HEXU: begin
                     du_ctl.op = DU_LOAD_HEX;
                     state_in  = ST_SCAN;
                  end
                  CONV_OCT: begin
                     du_ctl.op = DU_LOAD_OCT;
                     state_in  = ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_DABBLE: begin
            du_ctl.op = DU_DABBLE;
            iter_in   = iter_ff - ITER_W'(1);
            if (iter_ff == ITER_W'(1)) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // top-down search for the most significant nonzero digit
            priority if (rd_digit != 4'd0) begin
               dcnt_in  = DIG_CNT_W'(scan_idx_ff) + DIG_CNT_W'(1);
               state_in = ST_PREP;
            end else if (scan_idx_ff == '0) begin
               dcnt_in  = '0;
               state_in = ST_PREP;
            end else begin
               scan_idx_in = scan_idx_ff - DIG_IDX_W'(1);
            end
         end
         ST_PREP: begin
            ndig_in    = ndig_now;
            dig_idx_in = DIG_IDX_W'(dcnt_ff - DIG_CNT_W'(1));
            priority if (cfg.alt_form && mag_nz_ff &&
                         (conv_ff == CONV_HEXL || conv_ff == CONV_HEXU)) begin
               plen_in = 2'd2;
            end else if (cfg.alt_form && conv_ff == CONV_OCT && ndig_now == dcnt6) begin
               plen_in = 2'd1;  // octal alt form only when no precision zero leads
            end else begin
               plen_in = 2'd0;
            end
            sgn_in    = 1'b0;
            sgn_ch_in = CH_NUL;
            if (conv_ff == CONV_SDEC) begin
               priority if (neg_ff) begin
                  sgn_in    = 1'b1;
                  sgn_ch_in = CH_MINUS;
               end else if (cfg.sign_mode == SGN_PLUS) begin
                  sgn_in    = 1'b1;
                  sgn_ch_in = CH_PLUS;
               end else if (cfg.sign_mode == SGN_SPACE) begin
                  sgn_in    = 1'b1;
                  sgn_ch_in = CH_SPACE;
               end else begin
                  sgn_in    = 1'b0;
               end
            end
            state_in = ST_LAYOUT;
         end
         ST_LAYOUT: begin
            b1_in    = lead_sp;
            b2_in    = lead_sp + POS_W'(sgn_ff);
            b3_in    = lead_sp + POS_W'(sgn_ff) + POS_W'(plen_ff);
            b4_in    = lead_sp + POS_W'(sgn_ff) + POS_W'(plen_ff) + zpad + prec_zeros;
            b5_in    = lead_sp + POS_W'(sgn_ff) + POS_W'(plen_ff) + zpad + POS_W'(ndig_ff);
            total_in = body + pad;
            pos_in   = '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               empty_in     = 1'b0;
               pos_in       = pos_ff + POS_W'(1);
               last_in      = (pos_ff == total_ff - POS_W'(1));
               priority if (total_ff == '0) begin
                  char_in  = CH_NUL;
                  last_in  = 1'b1;
                  empty_in = 1'b1;
               end else if (pos_ff < b1_ff) begin
                  char_in = CH_SPACE;
               end else if (pos_ff < b2_ff) begin
                  char_in = sgn_ch_ff;
               end else if (pos_ff < b3_ff) begin
                  char_in = (pos_ff == b2_ff) ? CH_ZERO : (upper ? CH_UPPER_X : CH_LOWER_X);
               end else if (pos_ff < b4_ff) begin
                  char_in = CH_ZERO;
               end else if (pos_ff < b5_ff) begin
                  char_in    = digit_char(rd_digit, upper);
                  dig_idx_in = dig_idx_ff - DIG_IDX_W'(1);
               end else begin
                  char_in = CH_SPACE;
               end
               if (last_in) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         iter_ff      <= '0;
         dcnt_ff      <= '0;
         pos_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         iter_ff      <= iter_in;
         dcnt_ff      <= dcnt_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      conv_ff     <= conv_in;
      neg_ff      <= neg_in;
      mag_nz_ff   <= mag_nz_in;
      scan_idx_ff <= scan_idx_in;
      dig_idx_ff  <= dig_idx_in;
      ndig_ff     <= ndig_in;
      plen_ff     <= plen_in;
      sgn_ff      <= sgn_in;
      sgn_ch_ff   <= sgn_ch_in;
      b1_ff       <= b1_in;
      b2_ff       <= b2_in;
      b3_ff       <= b3_in;
      b4_ff       <= b4_in;
      b5_ff       <= b5_in;
      total_ff    <= total_in;
      char_ff     <= char_in;
      last_ff     <= last_in;
      empty_ff    <= empty_in;
   end

   // a new value always starts on the BCD unit or the scan
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_DABBLE || state_ff == ST_SCAN))
      else $error("accepted value did not start conversion");

   // the character position never runs past the field
   a_pos_in_field: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (pos_ff < total_ff || total_ff == '0))
      else $error("character position beyond field");

   // once the final character is taken and no new field is emitting, nothing follows
   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.ready && rsp_bus.last && state_ff != ST_EMIT)
      |=> !rsp_valid_ff)
      else $error("character issued after end of field");

   // an empty field is always a single, final transaction
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && empty_ff) |-> (last_ff && char_ff == CH_NUL))
      else $error("empty field result malformed");

   // digit count stays within the store
   a_dcnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PREP) |-> (dcnt_ff <= DIG_CNT_W'(MAX_DIGITS)))
      else $error("digit count out of range");

endmodule

`default_nettype wire

/* src/pifu_csr_regs.sv */
`timescale 1ns / 1ps
`default_nettype none

module pifu_csr_regs (
   input  logic               clock,
   input  logic               reset,
   pifu_csr_if.sink           csr_bus,
   output pifu_pkg::cfg_type  cfg
);
   import pifu_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_index_type'(csr_bus.reg_index))
            CSR_CONVERSION:  cfg_in.conversion  = csr_bus.wdata[2:0];
            CSR_LENGTH_MODE: cfg_in.length_mode = csr_bus.wdata[1:0];
            CSR_LEFT_JUST:   cfg_in.left_just   = csr_bus.wdata[0];
            CSR_SIGN_MODE:   cfg_in.sign_mode   = csr_bus.wdata[1:0];
            CSR_ZERO_PAD:    cfg_in.zero_pad    = csr_bus.wdata[0];
            CSR_ALT_FORM:    cfg_in.alt_form    = csr_bus.wdata[0];
            CSR_FIELD_WIDTH: cfg_in.field_width = csr_bus.wdata;
            CSR_MIN_DIGITS:  cfg_in.min_digits  = csr_bus.wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff            <= '0;
         cfg_ff.min_digits <= -7'sd1;  // precision not given
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

/* src/pifu_digit_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Digit store plus the shared shift-and-add-3 unit for binary to BCD.
module pifu_digit_unit (
   input  logic                            clock,
   input  pifu_pkg::du_ctl_type            ctl,
   input  logic [pifu_pkg::VALUE_W-1:0]    load_value,
   output logic [3:0]                      rd_digit
);
   import pifu_pkg::*;

   logic [3:0]                digits_ff [MAX_DIGITS];
   logic [3:0]                digits_in [MAX_DIGITS];
   logic [3:0]                adj       [MAX_DIGITS];
   logic [VALUE_W-1:0]        work_ff;
   logic [VALUE_W-1:0]        work_in;
   logic [4*MAX_DIGITS-1:0]   hex_ext;
   logic [3*MAX_DIGITS-1:0]   oct_ext;

   assign hex_ext  = (4*MAX_DIGITS)'(load_value);
   assign oct_ext  = (3*MAX_DIGITS)'(load_value);
   assign rd_digit = digits_ff[ctl.rd_idx];

   always_comb begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
         adj[i] = (digits_ff[i] >= 4'd5) ? digits_ff[i] + 4'd3 : digits_ff[i];
      end
   end

   always_comb begin
      digits_in = digits_ff;
      work_in   = work_ff;
      unique case (ctl.op)
         DU_HOLD: ;
         DU_LOAD_HEX: begin
            for (int i = 0; i < MAX_DIGITS; i++) digits_in[i] = hex_ext[4*i +: 4];
         end
         DU_LOAD_OCT: begin
            for (int i = 0; i < MAX_DIGITS; i++) digits_in[i] = {1'b0, oct_ext[3*i +: 3]};
         end
         DU_LOAD_DEC: begin
            for (int i = 0; i < MAX_DIGITS; i++) digits_in[i] = '0;
            work_in = load_value;
         end
         DU_DABBLE: begin
            // one bit enters per step, every BCD lane adjusted in parallel
            digits_in[0] = {adj[0][2:0], work_ff[VALUE_W-1]};
            for (int i = 1; i < MAX_DIGITS; i++) digits_in[i] = {adj[i][2:0], adj[i-1][3]};
            work_in = {work_ff[VALUE_W-2:0], 1'b0};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      digits_ff <= digits_in;
      work_ff   <= work_in;
   end

endmodule

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps

// Testbench for the printf integer field formatter.
// A shared task sends one raw value per transaction; a checker process compares each
// character transaction against the predicted field, oldest first.
module tb;
   import pifu_pkg::*;

   // Field limit of the default build: MAX_FIELD capped at the hard ceiling
   localparam int unsigned FIELD_LIMIT  = (MAX_FIELD_DEF < FIELD_CAP) ? MAX_FIELD_DEF : FIELD_CAP;
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned DRAIN_CYCLES = 200;   // idle wait after the final drain, for stray transactions
   localparam int unsigned GAP_PCT      = 10;    // chance in percent of a receiver stall or a send gap, each side

   // Register codes outside the defined ranges
   localparam logic [2:0] CONV_UNKNOWN = 3'd7;
   localparam logic [1:0] LEN_UNDEF    = 2'd3;
   localparam logic [1:0] SGN_UNDEF    = 2'd3;
   localparam logic [6:0] PREC_NONE    = 7'h7F;  // precision -1, not given

   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic              last;
      logic              empty_field;
   } field_char_type;

   logic clock = 1'b0;
   logic reset;

   pifu_csr_if csr_bus ();
   pifu_req_if req_bus ();
   pifu_rsp_if rsp_bus ();

   printf_integer_field_formatter_unit uut (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Predictor state: the format registers as last written, and the characters owed
   cfg_type        fmt_model;
   field_char_type expected_chars [$];
   int unsigned    mismatch_count = 0;
   int unsigned    cycle_count    = 0;
   bit             traffic_gaps   = 1'b1;  // cleared for the back-to-back stretch

   always #4 clock = ~clock;

   // Hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   // Receiver: stalls at random unless gaps are switched off
   always @(posedge clock) begin
      rsp_bus.ready <= !traffic_gaps || ($urandom_range(99) >= GAP_PCT);
   end

   // Every character transaction must match the oldest expected character
   always @(posedge clock) begin
      field_char_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_chars.size() == 0) begin
            $error("unexpected transaction: out_char %h last %b empty_field %b",
                   rsp_bus.out_char, rsp_bus.last, rsp_bus.empty_field);
            mismatch_count++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_bus.out_char !== want.out_char) begin
               $error("out_char: expected %h, actual %h", want.out_char, rsp_bus.out_char);
               mismatch_count++;
            end
            if (rsp_bus.last !== want.last) begin
               $error("last: expected %b, actual %b", want.last, rsp_bus.last);
               mismatch_count++;
            end
            if (rsp_bus.empty_field !== want.empty_field) begin
               $error("empty_field: expected %b, actual %b", want.empty_field,
                      rsp_bus.empty_field);
               mismatch_count++;
            end
         end
      end
   end

   // Formats one value under fmt_model and queues the characters it should produce
   function automatic void format_field(input logic [VALUE_W-1:0] raw);
      conv_type           conv;
      logic [VALUE_W-1:0] mask;
      logic [VALUE_W-1:0] sign_bit;
      logic [VALUE_W-1:0] mag;
      logic [VALUE_W-1:0] work;
      logic [3:0]         digits [MAX_DIGITS];
      logic [3:0]         d;
      int unsigned        radix, count, prec, ndig, body, width, pad, pfx_len;
      int                 i;
      logic               neg, has_prec, upper, zero_fill;
      logic [CHAR_W-1:0]  sign_ch, letter_a;
      logic [CHAR_W-1:0]  text [$];

      // conversions 5..7 behave as %u
      conv = (fmt_model.conversion > CONV_OCT) ? CONV_UDEC : conv_type'(fmt_model.conversion);
      case (fmt_model.length_mode)
         LEN_16: begin
            mask     = 64'h0000_0000_0000_FFFF;
            sign_bit = 64'h0000_0000_0000_8000;
         end
         LEN_64: begin
            mask     = '1;
            sign_bit = 64'h8000_0000_0000_0000;
         end
         default: begin  // 32-bit, also length mode 3
            mask     = 64'h0000_0000_FFFF_FFFF;
            sign_bit = 64'h0000_0000_8000_0000;
         end
      endcase

      mag = raw & mask;
      neg = (conv == CONV_SDEC) && ((mag & sign_bit) != 0);
      if (neg) mag = (~mag + 64'd1) & mask;  // unsigned negate, safe for most negative

      case (conv)
         CONV_SDEC, CONV_UDEC: radix = 10;
         CONV_OCT:             radix = 8;
         default:              radix = 16;
      endcase

      count = 0;
      work  = mag;
      while (work != 0 && count < MAX_DIGITS) begin
         digits[count] = 4'(work % radix);
         work = work / radix;
         count++;
      end

      has_prec = !fmt_model.min_digits[6];
      prec     = has_prec ? 32'(fmt_model.min_digits[5:0]) : 1;
      if (has_prec && prec > FIELD_LIMIT - 2) prec = FIELD_LIMIT - 2;
      ndig = (count > prec) ? count : prec;

      upper    = (conv == CONV_HEXU);
      letter_a = upper ? CH_UPPER_A : CH_LOWER_A;

      sign_ch = CH_NUL;
      if (conv == CONV_SDEC) begin
         if (neg)                                 sign_ch = CH_MINUS;
         else if (fmt_model.sign_mode == SGN_PLUS)  sign_ch = CH_PLUS;
         else if (fmt_model.sign_mode == SGN_SPACE) sign_ch = CH_SPACE;
      end

      pfx_len = 0;
      if (fmt_model.alt_form) begin
         if ((conv == CONV_HEXL || conv == CONV_HEXU) && mag != 0) pfx_len = 2;
         else if (conv == CONV_OCT && ndig == count)              pfx_len = 1;
      end

      body  = 32'(sign_ch != CH_NUL) + pfx_len + ndig;
      width = 32'(fmt_model.field_width);
      if (width > FIELD_LIMIT) width = FIELD_LIMIT;
      pad       = (width > body) ? width - body : 0;
      zero_fill = fmt_model.zero_pad && !fmt_model.left_just && !has_prec;

      if (!fmt_model.left_just && !zero_fill) repeat (pad) text.push_back(CH_SPACE);
      if (sign_ch != CH_NUL) text.push_back(sign_ch);
      if (pfx_len != 0) text.push_back(CH_ZERO);
      if (pfx_len == 2) text.push_back(upper ? CH_UPPER_X : CH_LOWER_X);
      if (zero_fill) repeat (pad) text.push_back(CH_ZERO);
      repeat (ndig - count) text.push_back(CH_ZERO);
      for (i = count; i > 0; i--) begin
         d = digits[i-1];
         text.push_back((d < 4'd10) ? CH_ZERO + {4'd0, d} : letter_a + {4'd0, d} - 8'd10);
      end
      if (fmt_model.left_just) repeat (pad) text.push_back(CH_SPACE);
      while (text.size() > FIELD_LIMIT) void'(text.pop_back());

      if (text.size() == 0) begin
         expected_chars.push_back('{out_char: CH_NUL, last: 1'b1, empty_field: 1'b1});
      end else begin
         foreach (text[k])
            expected_chars.push_back('{out_char: text[k], last: (k == text.size() - 1),
                                       empty_field: 1'b0});
      end
   endfunction

   function automatic cfg_type make_format(input logic [2:0] conv, input logic [1:0] len,
                                           input logic left, input logic [1:0] sgn,
                                           input logic zpad, input logic alt,
                                           input logic [6:0] width, input logic [6:0] prec);
      cfg_type f;
      f.conversion  = conv;
      f.length_mode = len;
      f.left_just   = left;
      f.sign_mode   = sgn;
      f.zero_pad    = zpad;
      f.alt_form    = alt;
      f.field_width = width;
      f.min_digits  = prec;
      return f;
   endfunction

   // Random format; mostly narrow fields, now and then full or oversized ones
   function automatic cfg_type random_format();
      logic [2:0] conv;
      logic [6:0] width;
      logic [6:0] prec;
      int         pick;
      conv = ($urandom_range(9) < 9) ? 3'($urandom_range(4)) : 3'($urandom_range(5, 7));
      pick = $urandom_range(9);
      if (pick < 7)      width = 7'($urandom_range(0, 24));
      else if (pick < 9) width = 7'($urandom_range(25, 64));
      else               width = 7'($urandom_range(65, 127));
      pick = $urandom_range(9);
      if (pick < 4)      prec = 7'h40 | 7'($urandom_range(63));  // sign bit set: not given
      else if (pick < 8) prec = 7'($urandom_range(0, 12));
      else               prec = 7'($urandom_range(13, 63));
      return make_format(conv, 2'($urandom_range(3)), 1'($urandom_range(1)),
                         2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                         width, prec);
   endfunction

   // Values biased toward zero, small numbers and sign boundaries
   function automatic logic [VALUE_W-1:0] random_value();
      logic [VALUE_W-1:0] v;
      case ($urandom_range(9))
         0:       v = '0;
         1:       v = 64'($urandom_range(0, 20));
         2:       v = '1;
         3: begin
            v = 64'd1 << $urandom_range(63);
            if ($urandom_range(1)) v = v - 64'd1;
         end
         default: v = {$urandom, $urandom};
      endcase
      return v;
   endfunction

   // Drops req valid and waits until every owed character has come back
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_bus.valid     <= 1'b1;
      csr_bus.reg_index <= idx;
      csr_bus.wdata     <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         CSR_CONVERSION:  fmt_model.conversion  = data[2:0];
         CSR_LENGTH_MODE: fmt_model.length_mode = data[1:0];
         CSR_LEFT_JUST:   fmt_model.left_just   = data[0];
         CSR_SIGN_MODE:   fmt_model.sign_mode   = data[1:0];
         CSR_ZERO_PAD:    fmt_model.zero_pad    = data[0];
         CSR_ALT_FORM:    fmt_model.alt_form    = data[0];
         CSR_FIELD_WIDTH: fmt_model.field_width = data;
         CSR_MIN_DIGITS:  fmt_model.min_digits  = data;
      endcase
   endtask

   // Registers change only with nothing in flight
   task automatic apply_format(input cfg_type f);
      wait_for_drain();
      write_csr(CSR_CONVERSION,  {4'd0, f.conversion});
      write_csr(CSR_LENGTH_MODE, {5'd0, f.length_mode});
      write_csr(CSR_LEFT_JUST,   {6'd0, f.left_just});
      write_csr(CSR_SIGN_MODE,   {5'd0, f.sign_mode});
      write_csr(CSR_ZERO_PAD,    {6'd0, f.zero_pad});
      write_csr(CSR_ALT_FORM,    {6'd0, f.alt_form});
      write_csr(CSR_FIELD_WIDTH, f.field_width);
      write_csr(CSR_MIN_DIGITS,  f.min_digits);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // One value transaction. Valid is left high on return so back-to-back sends
   // never drop it within a step; a gap lowers it before the next value is driven.
   task automatic send_value(input logic [VALUE_W-1:0] v);
      if (traffic_gaps && $urandom_range(99) < GAP_PCT) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.raw_value <= v;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      format_field(v);
   endtask

   task automatic format_one(input cfg_type f, input logic [VALUE_W-1:0] v);
      apply_format(f);
      send_value(v);
   endtask

   // Field extremes, every conversion and each corner of the format rules
   task automatic test_directed_formats();
      // plain zero, 32-bit most negative, 64-bit most negative, 64-bit most positive with plus
      format_one(make_format(CONV_SDEC, LEN_32, 0, SGN_MINUS, 0, 0, 0, PREC_NONE), 64'd0);
      format_one(make_format(CONV_SDEC, LEN_32, 0, SGN_MINUS, 0, 0, 0, PREC_NONE),
                 64'hFFFF_FFFF_8000_0000);
      format_one(make_format(CONV_SDEC, LEN_64, 0, SGN_MINUS, 0, 0, 0, PREC_NONE),
                 64'h8000_0000_0000_0000);
      format_one(make_format(CONV_SDEC, LEN_64, 0, SGN_PLUS, 0, 0, 0, PREC_NONE),
                 64'h7FFF_FFFF_FFFF_FFFF);
      // widest magnitudes in decimal, octal and hex
      format_one(make_format(CONV_UDEC, LEN_64, 0, SGN_MINUS, 0, 0, 0, PREC_NONE), '1);
      format_one(make_format(CONV_OCT, LEN_64, 0, SGN_MINUS, 0, 1, 0, PREC_NONE), '1);
      format_one(make_format(CONV_HEXL, LEN_64, 0, SGN_MINUS, 0, 1, 0, PREC_NONE),
                 64'hDEAD_BEEF_CAFE_F00D);
      format_one(make_format(CONV_HEXU, LEN_64, 0, SGN_MINUS, 1, 1, 24, PREC_NONE),
                 64'h0123_4567_89AB_CDEF);
      // zero with precision zero: empty unless a sign or octal 0 survives
      format_one(make_format(CONV_SDEC, LEN_32, 0, SGN_MINUS, 0, 0, 0, 7'd0), 64'd0);
      format_one(make_format(CONV_UDEC, LEN_32, 0, SGN_MINUS, 0, 0, 0, 7'd0), 64'd0);
      format_one(make_format(CONV_HEXL, LEN_32, 0, SGN_MINUS, 0, 1, 0, 7'd0), 64'd0);
      format_one(make_format(CONV_OCT, LEN_32, 0, SGN_MINUS, 0, 1, 0, 7'd0), 64'd0);
      format_one(make_format(CONV_SDEC, LEN_32, 0, SGN_SPACE, 0, 0, 0, 7'd0), 64'd0);
      // full-width fields, zero padded and left aligned
      format_one(make_format(CONV_SDEC, LEN_32, 0, SGN_MINUS, 1, 0, 64, PREC_NONE),
                 64'h0000_0000_FFFF_FFFB);
      format_one(make_format(CONV_SDEC, LEN_32, 1, SGN_PLUS, 0, 0, 64, PREC_NONE), 64'd123);
      // oversized width and precision saturate
      format_one(make_format(CONV_SDEC, LEN_32, 0, SGN_MINUS, 0, 0, 127, PREC_NONE), 64'd9);
      format_one(make_format(CONV_SDEC, LEN_32, 0, SGN_PLUS, 0, 0, 0, 7'd63), 64'd7);
      format_one(make_format(CONV_HEXL, LEN_32, 0, SGN_MINUS, 0, 1, 64, 7'd62), 64'd1);
      // undefined codes fall back to %u, 32-bit and minus-only
      format_one(make_format(CONV_UNKNOWN, LEN_32, 0, SGN_MINUS, 0, 0, 0, PREC_NONE),
                 64'h0000_0000_FFFF_FFFF);
      format_one(make_format(CONV_SDEC, LEN_UNDEF, 0, SGN_MINUS, 0, 0, 0, PREC_NONE),
                 64'h0000_0001_8000_0001);
      format_one(make_format(CONV_SDEC, LEN_32, 0, SGN_UNDEF, 0, 0, 0, PREC_NONE), 64'd5);
      // 16-bit sign extension ignores upper garbage
      format_one(make_format(CONV_SDEC, LEN_16, 0, SGN_MINUS, 0, 0, 0, PREC_NONE),
                 64'hA5A5_A5A5_A5A5_8000);
      // zero pad ignored once a precision is given
      format_one(make_format(CONV_SDEC, LEN_32, 0, SGN_MINUS, 1, 0, 10, 7'd3), 64'd42);
      // octal precision zeros replace the alternate 0
      format_one(make_format(CONV_OCT, LEN_32, 0, SGN_MINUS, 0, 1, 0, 7'd5), 64'd8);
      // precision -64 is still "not given"
      format_one(make_format(CONV_UDEC, LEN_32, 0, SGN_MINUS, 1, 0, 8, 7'h40), 64'd77);
   endtask

   // Random formats, a handful of values each
   task automatic test_random_formats();
      repeat (30) begin
         apply_format(random_format());
         repeat ($urandom_range(6, 14)) send_value(random_value());
      end
   endtask

   // A long stretch with neither side idling
   task automatic test_back_to_back();
      traffic_gaps = 1'b0;
      apply_format(random_format());
      repeat (40) send_value(random_value());
      wait_for_drain();
      traffic_gaps = 1'b1;
   endtask

   initial begin
      // defaults match the block's registers after reset
      fmt_model = make_format(CONV_SDEC, LEN_32, 0, SGN_MINUS, 0, 0, 0, PREC_NONE);
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.raw_value = '0;
      csr_bus.valid     = 1'b0;
      csr_bus.reg_index = CSR_CONVERSION;
      csr_bus.wdata     = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_formats();
      test_random_formats();
      test_back_to_back();

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);  // catch any stray transaction
      if (mismatch_count == 0 && expected_chars.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
